[sv/san_pkg.sv]
// Shared types, codes and constants of the smoke alarm network controller.
package san_pkg;

	localparam int CNT_W     = 16;
	localparam int MAX_WR    = 5;
	localparam int WR_IDX_W  = $clog2(MAX_WR);
	localparam int WR_CNT_W  = $clog2(MAX_WR + 1);
	localparam int CFG_DW    = 16;
	localparam int CFG_IW    = 2;

	localparam logic [15:0] ALARM_INTERVAL_RST = 16'd60;
	localparam logic [15:0] TEST_INTERVAL_RST  = 16'd60;
	localparam logic [7:0]  ALARM_DELAY_RST    = 8'd0;
	localparam logic [5:0]  SEND_FLAGS_RST     = 6'd0;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ALARM_INTERVAL = 2'd0,
		CFG_TEST_INTERVAL  = 2'd1,
		CFG_ALARM_DELAY    = 2'd2,
		CFG_SEND_FLAGS     = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_ALARM_TG  = 3'd0,
		MODE_TEST_TG   = 3'd1,
		MODE_RESET_TG  = 3'd2,
		MODE_STATUS    = 3'd3,
		MODE_BUTTON    = 3'd4,
		MODE_SECOND    = 3'd5,
		MODE_MINUTE    = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		OBJ_NET_ALARM   = 3'd0,
		OBJ_STATUS      = 3'd1,
		OBJ_NET_TEST    = 3'd2,
		OBJ_TEST_STATUS = 3'd3,
		OBJ_DELAYED     = 3'd4,
		OBJ_RESET       = 3'd5
	} obj_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_ALARM = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	// bit positions in send_flags
	localparam int SF_DELAYED       = 0;
	localparam int SF_STATUS_PER    = 1;
	localparam int SF_NET_PER       = 2;
	localparam int SF_IDLE_STAT_PER = 3;
	localparam int SF_TEST_STAT_PER = 4;
	localparam int SF_TEST_NET_PER  = 5;

	typedef struct packed {
		logic [2:0] mode;
		logic       telegram_value;
		logic       local_alarm;
		logic       local_test;
		logic       bus_alarm;
		logic       bus_test;
	} in_item_t;

	typedef struct packed {
		logic       write_valid;
		logic [2:0] object_id;
		logic       object_value;
		logic       last;
		logic [1:0] device_command;
		logic       alarm_active;
	} out_item_t;

	// all writes of one event, handed from front to back
	typedef struct packed {
		logic [WR_CNT_W-1:0]      n;
		logic [MAX_WR-1:0][2:0]   ids;
		logic [MAX_WR-1:0]        vals;
		logic [1:0]               cmd;
		logic                     act;
	} job_t;

	function automatic job_t push_wr(job_t j, obj_t id, logic v);
		job_t r;
		r = j;
		if (r.n < WR_CNT_W'(MAX_WR)) begin
			r.ids[r.n[WR_IDX_W-1:0]]  = id;
			r.vals[r.n[WR_IDX_W-1:0]] = v;
			r.n = r.n + WR_CNT_W'(1);
		end
		return r;
	endfunction

endpackage

[sv/san_front.sv]
// Front part: configuration registers, event state and the write list of each event.
module san_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  san_pkg::in_item_t           in_item,
	input  logic                        cfg_we,
	input  logic [san_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [san_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                        q_full,
	output logic                        q_push,
	output san_pkg::job_t               q_job
);

	logic [15:0] alarm_interval_q, test_interval_q;
	logic [7:0]  alarm_delay_q;
	logic [5:0]  send_flags_q;

	logic own_alarm_q, own_test_q, remote_alarm_q, remote_test_q;
	logic wanted_alarm_q, wanted_test_q, ignore_remote_q, delayed_sent_q;
	logic [7:0] delay_count_q;
	logic [san_pkg::CNT_W-1:0] network_count_q, status_count_q, test_count_q;

	logic own_alarm_d, own_test_d, remote_alarm_d, remote_test_d;
	logic wanted_alarm_d, wanted_test_d, ignore_remote_d, delayed_sent_d;
	logic [7:0] delay_count_d;
	logic [san_pkg::CNT_W-1:0] network_count_d, status_count_d, test_count_d;
	logic [san_pkg::CNT_W-1:0] alarm_reload, test_reload;
	san_pkg::job_t job;
	logic accept;

	assign in_stall     = q_full;
	assign accept       = in_valid && !q_full;
	assign q_push       = accept;
	assign q_job        = job;
	assign alarm_reload = san_pkg::CNT_W'(alarm_interval_q);
	assign test_reload  = san_pkg::CNT_W'(test_interval_q);

	always_comb begin
		own_alarm_d     = own_alarm_q;
		own_test_d      = own_test_q;
		remote_alarm_d  = remote_alarm_q;
		remote_test_d   = remote_test_q;
		wanted_alarm_d  = wanted_alarm_q;
		wanted_test_d   = wanted_test_q;
		ignore_remote_d = ignore_remote_q;
		delayed_sent_d  = delayed_sent_q;
		delay_count_d   = delay_count_q;
		network_count_d = network_count_q;
		status_count_d  = status_count_q;
		test_count_d    = test_count_q;
		job             = '0;

		case (in_item.mode)
			san_pkg::MODE_ALARM_TG: begin
				wanted_alarm_d = in_item.telegram_value;
				if (!in_item.telegram_value && own_alarm_q && delay_count_q == 8'd0) begin
					network_count_d = alarm_reload;
					job = san_pkg::push_wr(job, san_pkg::OBJ_NET_ALARM, own_alarm_q);
				end
				if (ignore_remote_q) wanted_alarm_d = 1'b0;
			end
			san_pkg::MODE_TEST_TG: begin
				wanted_test_d = in_item.telegram_value;
				if (!in_item.telegram_value && own_test_q)
					job = san_pkg::push_wr(job, san_pkg::OBJ_NET_TEST, own_test_q);
				if (ignore_remote_q) wanted_test_d = 1'b0;
			end
			san_pkg::MODE_RESET_TG: begin
				wanted_alarm_d  = 1'b0;
				wanted_test_d   = 1'b0;
				ignore_remote_d = 1'b1;
			end
			san_pkg::MODE_STATUS: begin
				if (own_alarm_q != in_item.local_alarm) begin
					own_alarm_d = in_item.local_alarm;
					if (in_item.local_alarm && send_flags_q[san_pkg::SF_DELAYED]) begin
						delay_count_d = alarm_delay_q;
					end else begin
						delay_count_d = 8'd0;
					end
					if ((delay_count_d != 8'd0) != delayed_sent_d) begin
						delayed_sent_d = (delay_count_d != 8'd0);
						job = san_pkg::push_wr(job, san_pkg::OBJ_DELAYED, delayed_sent_d);
					end
					if (!(in_item.local_alarm && send_flags_q[san_pkg::SF_DELAYED])) begin
						network_count_d = alarm_reload;
						job = san_pkg::push_wr(job, san_pkg::OBJ_NET_ALARM, own_alarm_d);
					end
					status_count_d = alarm_reload;
					job = san_pkg::push_wr(job, san_pkg::OBJ_STATUS, own_alarm_d);
				end
				if (own_test_q != in_item.local_test) begin
					own_test_d = in_item.local_test;
					job = san_pkg::push_wr(job, san_pkg::OBJ_NET_TEST, own_test_d);
					test_count_d = test_reload;
					job = san_pkg::push_wr(job, san_pkg::OBJ_TEST_STATUS, own_test_d);
				end
				remote_alarm_d = in_item.bus_alarm;
				remote_test_d  = in_item.bus_test;
			end
			san_pkg::MODE_BUTTON: begin
				if (wanted_alarm_q) begin
					wanted_alarm_d = 1'b0;
					delay_count_d  = 8'd0;
					if (delayed_sent_q) begin
						delayed_sent_d = 1'b0;
						job = san_pkg::push_wr(job, san_pkg::OBJ_DELAYED, 1'b0);
					end
				end
				wanted_test_d = 1'b0;
			end
			san_pkg::MODE_SECOND: begin
				if (own_alarm_q) begin
					if (delay_count_q != 8'd0) begin
						delay_count_d = delay_count_q - 8'd1;
						if ((delay_count_d != 8'd0) != delayed_sent_q) begin
							delayed_sent_d = (delay_count_d != 8'd0);
							job = san_pkg::push_wr(job, san_pkg::OBJ_DELAYED, delayed_sent_d);
						end
						if (delay_count_d == 8'd0) begin
							network_count_d = alarm_reload;
							job = san_pkg::push_wr(job, san_pkg::OBJ_NET_ALARM, own_alarm_q);
						end
					end else if (send_flags_q[san_pkg::SF_STATUS_PER]) begin
						status_count_d = status_count_q - san_pkg::CNT_W'(1);
						if (status_count_d == '0) begin
							status_count_d = alarm_reload;
							job = san_pkg::push_wr(job, san_pkg::OBJ_STATUS, own_alarm_q);
						end
						if (send_flags_q[san_pkg::SF_NET_PER]) begin
							network_count_d = network_count_q - san_pkg::CNT_W'(1);
							if (network_count_d == '0) begin
								network_count_d = alarm_reload;
								job = san_pkg::push_wr(job, san_pkg::OBJ_NET_ALARM,
									own_alarm_q);
							end
						end
					end
				end else if (send_flags_q[san_pkg::SF_IDLE_STAT_PER]) begin
					status_count_d = status_count_q - san_pkg::CNT_W'(1);
					if (status_count_d == '0) begin
						status_count_d = alarm_reload;
						job = san_pkg::push_wr(job, san_pkg::OBJ_STATUS, own_alarm_q);
					end
				end
				if (own_test_q && send_flags_q[san_pkg::SF_TEST_STAT_PER]) begin
					test_count_d = test_count_q - san_pkg::CNT_W'(1);
					if (test_count_d == '0) begin
						if (send_flags_q[san_pkg::SF_TEST_NET_PER])
							job = san_pkg::push_wr(job, san_pkg::OBJ_NET_TEST, own_test_q);
						test_count_d = test_reload;
						job = san_pkg::push_wr(job, san_pkg::OBJ_TEST_STATUS, own_test_q);
					end
				end
			end
			san_pkg::MODE_MINUTE: begin
				if (ignore_remote_q && !(remote_alarm_q || remote_test_q)) begin
					ignore_remote_d = 1'b0;
					job = san_pkg::push_wr(job, san_pkg::OBJ_RESET, 1'b0);
				end
			end
			default: begin
			end
		endcase

		// detector command from the state after the event
		if (wanted_alarm_d) begin
			job.cmd = remote_alarm_d ? san_pkg::CMD_NONE : san_pkg::CMD_ALARM;
		end else if (wanted_test_d) begin
			job.cmd = remote_test_d ? san_pkg::CMD_NONE : san_pkg::CMD_TEST;
		end else if (remote_alarm_d || remote_test_d) begin
			job.cmd = san_pkg::CMD_STOP;
		end else begin
			job.cmd = san_pkg::CMD_NONE;
		end
		job.act = own_alarm_d || remote_alarm_d || own_test_d || remote_test_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_interval_q <= san_pkg::ALARM_INTERVAL_RST;
			test_interval_q  <= san_pkg::TEST_INTERVAL_RST;
			alarm_delay_q    <= san_pkg::ALARM_DELAY_RST;
			send_flags_q     <= san_pkg::SEND_FLAGS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				san_pkg::CFG_ALARM_INTERVAL: alarm_interval_q <= cfg_data;
				san_pkg::CFG_TEST_INTERVAL:  test_interval_q  <= cfg_data;
				san_pkg::CFG_ALARM_DELAY:    alarm_delay_q    <= cfg_data[7:0];
				san_pkg::CFG_SEND_FLAGS:     send_flags_q     <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_alarm_q     <= 1'b0;
			own_test_q      <= 1'b0;
			remote_alarm_q  <= 1'b0;
			remote_test_q   <= 1'b0;
			wanted_alarm_q  <= 1'b0;
			wanted_test_q   <= 1'b0;
			ignore_remote_q <= 1'b0;
			delayed_sent_q  <= 1'b0;
			delay_count_q   <= 8'd0;
			network_count_q <= san_pkg::CNT_W'(san_pkg::ALARM_INTERVAL_RST);
			status_count_q  <= san_pkg::CNT_W'(san_pkg::ALARM_INTERVAL_RST);
			test_count_q    <= san_pkg::CNT_W'(san_pkg::TEST_INTERVAL_RST);
		end else if (accept) begin
			own_alarm_q     <= own_alarm_d;
			own_test_q      <= own_test_d;
			remote_alarm_q  <= remote_alarm_d;
			remote_test_q   <= remote_test_d;
			wanted_alarm_q  <= wanted_alarm_d;
			wanted_test_q   <= wanted_test_d;
			ignore_remote_q <= ignore_remote_d;
			delayed_sent_q  <= delayed_sent_d;
			delay_count_q   <= delay_count_d;
			network_count_q <= network_count_d;
			status_count_q  <= status_count_d;
			test_count_q    <= test_count_d;
		end
	end

endmodule

[sv/san_queue.sv]
// Two-entry queue of event write lists between front and back.
module san_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  san_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output san_pkg::job_t head_job
);

	san_pkg::job_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/san_back.sv]
// Back part: walks each write list and drives one result item per cycle while the output is not stalled.
module san_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  san_pkg::job_t      head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output san_pkg::out_item_t out_item
);

	logic [san_pkg::WR_IDX_W-1:0] idx_q;
	logic                         out_valid_q;
	san_pkg::out_item_t           out_q;
	san_pkg::out_item_t           next_item;
	logic                         load, is_last;

	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign is_last   = (head_job.n == '0) ||
	                   (san_pkg::WR_CNT_W'(idx_q) + san_pkg::WR_CNT_W'(1) == head_job.n);
	assign pop       = load && is_last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		next_item                = '0;
		next_item.last           = is_last;
		next_item.device_command = head_job.cmd;
		next_item.alarm_active   = head_job.act;
		if (head_job.n != '0) begin
			next_item.write_valid  = 1'b1;
			next_item.object_id    = head_job.ids[idx_q];
			next_item.object_value = head_job.vals[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= next_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + san_pkg::WR_IDX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/smoke_alarm_network_controller.sv]
// Top level of the smoke alarm network controller.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item   (san_pkg::in_item_t)
//   out      output     out_valid / out_stall out_item  (san_pkg::out_item_t)
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// An event is taken every cycle while the two-entry queue has room; its state
// update finishes in that cycle. Each event yields one to five result items,
// one per cycle from the output register while out_stall is low, so the output
// port sets the rate. The first result passes through the queue and then the
// output register before it is valid at the output. Reset clears all flags,
// loads the interval counters with 60 and empties the queue; no sweep follows.
// A stalled output holds its register and backs up through the queue to in_stall.
module smoke_alarm_network_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  san_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output san_pkg::out_item_t          out_item,
	input  logic                        cfg_we,
	input  logic [san_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [san_pkg::CFG_DW-1:0]  cfg_data
);

	logic          q_full, q_push, q_pop, q_head_valid;
	san_pkg::job_t q_job, q_head_job;

	san_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	san_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	san_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
